>>> rtl/core/skrc_pkg.sv
`default_nettype none

package skrc_pkg;

  localparam int KEY_LEN_W     = 4;
  localparam int REQ_W         = 2;
  localparam int CODE_W        = 5;
  localparam int RC_W          = 21;
  localparam int BUCKET_OUT_W  = 16;
  localparam int FOLD_BASE     = 29;
  localparam int RANGE_LIMIT   = 1048575;
  // restoring reduction by 16T, 8T, 4T, 2T, T brings a fold below T
  localparam int RED_STEPS     = 5;
  localparam int RED_CNT_W     = 3;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd4;

  localparam logic [REQ_W-1:0] REQ_KEY   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOW   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HIGH  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FOLD,
    ST_CHECK,
    ST_KEY_RD,
    ST_KEY_WR,
    ST_Q_HIGH,
    ST_Q_LOW,
    ST_Q_OUT,
    ST_BUILD
  } state_t;

  typedef struct packed {
    logic load;
    logic fold_start;
    logic fold_zero;
    logic fold_step;
    logic pos_inc;
    logic end_string;
    logic save_low;
    logic rd_bucket;
    logic rd_low_m1;
    logic key_wr;
    logic out_load;
    logic sweep_init;
    logic sweep_step;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             last;
    logic             pos_lt;
    logic             fold_last;
    logic             multi_step;
    logic             out_free;
    logic             cnt_last;
    logic             sweep_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/string_key_range_counter_core.sv
`default_nettype none

// String key range counter. Strings stream in one letter per transfer; each is padded
// or cut to key_length letters and hashed base 29 modulo TABLE_SIZE into a bucket of a
// count table held in one simple dual-port memory. Key strings bump their bucket
// (saturating), the first build transfer turns the table into saturating prefix sums in
// one pipelined sweep (later builds do nothing), and a query (low string, then high
// string) returns prefix(high) - prefix(low-1) along with both bucket indices. After
// reset the table is cleared with in_ready low. A letter is accepted, decoded and
// checked; when TABLE_SIZE is not a power of two a fold state in between runs the
// restoring reduction, one step per cycle. At a string's end each pad letter takes one
// more pass through the check state, and the fold state if TABLE_SIZE is not a power of
// two. A key end adds a read-modify-write of its bucket; a query end reads the high
// bucket and bucket low-1, then waits for the output register to be free. A build holds
// input off during its sweep, bounded by one memory read and one write per cycle.
module string_key_range_counter_core #(
  parameter int TABLE_SIZE  = 65536,
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [skrc_pkg::REQ_W-1:0]        req_type,
  input  wire logic [skrc_pkg::CODE_W-1:0]       letter_code,
  input  wire logic                              last_letter,
  input  wire logic                              cfg_wr_en,
  input  wire logic [skrc_pkg::KEY_LEN_W-1:0]    cfg_wr_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [skrc_pkg::RC_W-1:0]       range_count,
  output logic [skrc_pkg::BUCKET_OUT_W-1:0]      low_bucket,
  output logic [skrc_pkg::BUCKET_OUT_W-1:0]      high_bucket
);
  import skrc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skrc_dp #(
    .TABLE_SIZE  (TABLE_SIZE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .letter_code (letter_code),
    .last_letter (last_letter),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .range_count (range_count),
    .low_bucket  (low_bucket),
    .high_bucket (high_bucket),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

>>> rtl/core/skrc_dp.sv
`default_nettype none

module skrc_dp #(
  parameter int TABLE_SIZE  = 65536,
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [skrc_pkg::REQ_W-1:0]        req_type,
  input  wire logic [skrc_pkg::CODE_W-1:0]       letter_code,
  input  wire logic                              last_letter,
  input  wire logic                              cfg_wr_en,
  input  wire logic [skrc_pkg::KEY_LEN_W-1:0]    cfg_wr_data,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic signed [skrc_pkg::RC_W-1:0]       range_count,
  output logic [skrc_pkg::BUCKET_OUT_W-1:0]      low_bucket,
  output logic [skrc_pkg::BUCKET_OUT_W-1:0]      high_bucket,
  input  wire skrc_pkg::dp_cmd_t                 cmd,
  output skrc_pkg::dp_stat_t                     stat
);
  import skrc_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int PW = IW + CODE_W;
  localparam int CW = COUNT_WIDTH;
  localparam int SW = (CW + 1 > RC_W + 1) ? CW + 1 : RC_W + 1;
  localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  logic [KEY_LEN_W-1:0] key_length;
  logic [REQ_W-1:0]     req_q;
  logic [CODE_W-1:0]    code_q;
  logic                 last_q;
  logic [IW-1:0]        acc;
  logic [KEY_LEN_W-1:0] pos;
  logic [IW-1:0]        bucket;
  logic [IW-1:0]        saved_low;
  logic [PW-1:0]        prod;
  logic [RED_CNT_W-1:0] red_k;
  logic [IW:0]          cnt;
  logic [CW-1:0]        run;
  logic [CW-1:0]        hi_val;
  logic                 low_zero;

  logic [CW-1:0] mem [TABLE_SIZE];
  logic [CW-1:0] rd_data;

  // fold: acc * 29 + code, then reduce modulo the table size
  logic [CODE_W-1:0] code_eff;
  logic [PW-1:0]     prod_full;
  logic [PW-1:0]     thresh;
  logic [PW-1:0]     red_val;

  assign code_eff  = cmd.fold_zero ? '0 : code_q;
  assign prod_full = PW'(acc) * PW'(FOLD_BASE) + PW'(code_eff);
  assign thresh    = PW'(TABLE_SIZE) << red_k;
  assign red_val   = (prod >= thresh) ? prod - thresh : prod;

  // memory addressing
  logic [IW:0]    cnt_m1;
  logic [IW-1:0]  low_m1;
  logic           sweep_rd;
  logic           sweep_wr;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [CW-1:0]  wr_data;
  logic [CW:0]    run_sum;
  logic [CW-1:0]  run_sat;
  logic [CW-1:0]  inc_val;

  assign cnt_m1   = cnt - 1'b1;
  assign low_m1   = saved_low - 1'b1;
  assign sweep_rd = cmd.sweep_step && (cnt < (IW+1)'(TABLE_SIZE));
  assign sweep_wr = cmd.sweep_step && (cnt != '0);
  assign run_sum  = {1'b0, run} + {1'b0, rd_data};
  assign run_sat  = run_sum[CW] ? '1 : run_sum[CW-1:0];
  assign inc_val  = (rd_data != '1) ? rd_data + 1'b1 : rd_data;

  always_comb begin
    rd_en   = cmd.rd_bucket || cmd.rd_low_m1 || sweep_rd;
    rd_addr = cnt[IW-1:0];
    if (cmd.rd_bucket) begin
      rd_addr = bucket;
    end else if (cmd.rd_low_m1) begin
      rd_addr = low_m1;
    end
  end

  always_comb begin
    wr_en   = cmd.clear_step || cmd.key_wr || sweep_wr;
    wr_addr = cnt[IW-1:0];
    wr_data = '0;
    if (cmd.key_wr) begin
      wr_addr = bucket;
      wr_data = inc_val;
    end else if (sweep_wr) begin
      wr_addr = cnt_m1[IW-1:0];
      wr_data = run_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // query difference, saturated to the output range
  logic [CW-1:0]          lo_val;
  logic signed [SW-1:0]   diff;
  logic signed [SW-1:0]   lim_pos;
  logic signed [SW-1:0]   lim_neg;
  logic signed [SW-1:0]   diff_sat;

  assign lo_val  = low_zero ? '0 : rd_data;
  assign diff    = $signed(SW'(hi_val)) - $signed(SW'(lo_val));
  assign lim_pos = SW'(RANGE_LIMIT);
  assign lim_neg = -lim_pos;

  always_comb begin
    diff_sat = diff;
    if (diff > lim_pos) begin
      diff_sat = lim_pos;
    end else if (diff < lim_neg) begin
      diff_sat = lim_neg;
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
      acc        <= '0;
      pos        <= '0;
      saved_low  <= '0;
      cnt        <= '0;
      red_k      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_length <= cfg_wr_data;
      end
      if (cmd.fold_start) begin
        if (IS_POW2) begin
          acc <= prod_full[IW-1:0];
        end
        red_k <= RED_CNT_W'(RED_STEPS - 1);
      end
      if (cmd.fold_step) begin
        red_k <= red_k - 1'b1;
        if (red_k == '0) begin
          acc <= red_val[IW-1:0];
        end
      end
      if (cmd.pos_inc) begin
        pos <= pos + 1'b1;
      end
      if (cmd.end_string) begin
        acc <= '0;
        pos <= '0;
        if (cmd.save_low) begin
          saved_low <= acc;
        end
      end
      if (cmd.sweep_init) begin
        cnt <= '0;
      end else if (cmd.sweep_step || cmd.clear_step) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      code_q <= letter_code;
      last_q <= last_letter;
    end
    if (cmd.fold_start) begin
      prod <= prod_full;
    end else if (cmd.fold_step) begin
      prod <= red_val;
    end
    if (cmd.end_string) begin
      bucket <= acc;
    end
    if (cmd.sweep_init) begin
      run <= '0;
    end else if (sweep_wr) begin
      run <= run_sat;
    end
    if (cmd.rd_low_m1) begin
      hi_val   <= rd_data;
      low_zero <= (saved_low == '0);
    end
    if (cmd.out_load) begin
      range_count <= diff_sat[RC_W-1:0];
      low_bucket  <= BUCKET_OUT_W'(saved_low);
      high_bucket <= BUCKET_OUT_W'(bucket);
    end
  end

  always_comb begin
    stat.req        = req_q;
    stat.last       = last_q;
    stat.pos_lt     = pos < key_length;
    stat.fold_last  = (red_k == '0);
    stat.multi_step = !IS_POW2;
    stat.out_free   = !out_valid || out_ready;
    stat.cnt_last   = (cnt == (IW+1)'(TABLE_SIZE - 1));
    stat.sweep_done = (cnt == (IW+1)'(TABLE_SIZE));
  end

endmodule

`default_nettype wire

>>> rtl/core/skrc_ctrl.sv
`default_nettype none

module skrc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire skrc_pkg::dp_stat_t stat,
  output skrc_pkg::dp_cmd_t       cmd
);
  import skrc_pkg::*;

  state_t state;
  state_t state_next;
  logic   built;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      built <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_BUILD && stat.sweep_done) begin
        built <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.req == REQ_BUILD) begin
          state_next = built ? ST_IDLE : ST_BUILD;
        end else if (stat.pos_lt && stat.multi_step) begin
          state_next = ST_FOLD;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_FOLD: begin
        if (stat.fold_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.last) begin
          state_next = ST_IDLE;
        end else if (stat.pos_lt) begin
          state_next = stat.multi_step ? ST_FOLD : ST_CHECK;
        end else begin
          case (stat.req)
            REQ_KEY:  state_next = ST_KEY_RD;
            REQ_HIGH: state_next = ST_Q_HIGH;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_KEY_RD: state_next = ST_KEY_WR;
      ST_KEY_WR: state_next = ST_IDLE;
      ST_Q_HIGH: state_next = ST_Q_LOW;
      ST_Q_LOW:  state_next = ST_Q_OUT;
      ST_Q_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_BUILD: begin
        if (stat.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        if (stat.req == REQ_BUILD) begin
          cmd.sweep_init = !built;
        end else if (stat.pos_lt) begin
          cmd.fold_start = 1'b1;
          cmd.pos_inc    = 1'b1;
        end
      end
      ST_FOLD: cmd.fold_step = 1'b1;
      ST_CHECK: begin
        if (stat.last) begin
          if (stat.pos_lt) begin
            // pad the string with zero codes
            cmd.fold_start = 1'b1;
            cmd.fold_zero  = 1'b1;
            cmd.pos_inc    = 1'b1;
          end else begin
            cmd.end_string = 1'b1;
            cmd.save_low   = (stat.req == REQ_LOW);
          end
        end
      end
      ST_KEY_RD: cmd.rd_bucket = 1'b1;
      ST_KEY_WR: cmd.key_wr = 1'b1;
      ST_Q_HIGH: cmd.rd_bucket = 1'b1;
      ST_Q_LOW:  cmd.rd_low_m1 = 1'b1;
      ST_Q_OUT:  cmd.out_load = stat.out_free;
      ST_BUILD:  cmd.sweep_step = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
